### hdl/tpts_pkg.sv
// Types, constants and grading functions for the track protection trait scorer.
`default_nettype none

package tpts_pkg;

    localparam int LENGTH_BITS = 18;
    localparam int COUNT_BITS  = 18;
    localparam int REV_W       = 8;
    localparam int TRACK_W     = 8;
    localparam int SEV_W       = 7;
    localparam int INCR_W      = 5;
    localparam int TYPE_W      = 3;
    localparam int CNT_W       = 16;
    localparam int NUM_TRAITS  = 6;
    localparam int S_TDATA_W   = ((REV_W + 4 * COUNT_BITS + 2 * LENGTH_BITS + 2 + TRACK_W + 7)
                                  / 8) * 8;
    localparam int M_TDATA_W   = 64;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    typedef logic [SEV_W-1:0]       sev_t;
    typedef logic [INCR_W-1:0]      incr_t;
    typedef logic [LENGTH_BITS-1:0] len_t;
    typedef logic [COUNT_BITS-1:0]  count_t;
    typedef logic [CNT_W-1:0]       cnt_t;

    typedef enum logic [TYPE_W-1:0] {
        TRAIT_WEAK    = 3'd0,
        TRAIT_LONG    = 3'd1,
        TRAIT_SHORT   = 3'd2,
        TRAIT_HALF    = 3'd3,
        TRAIT_ILLEGAL = 3'd4,
        TRAIT_SYNC    = 3'd5
    } trait_t;

    typedef struct packed {
        logic [TRACK_W-1:0] track_number;
        logic               half_has_data;
        logic               half_position;
        len_t               length_max;
        len_t               length_min;
        count_t             longest_sync_bits;
        count_t             illegal_code_count;
        count_t             weak_max_run;
        count_t             weak_total;
        logic [REV_W-1:0]   revolutions;
    } item_t;

    localparam logic KIND_HIT    = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic REG_HIT_CAPACITY = 1'b0;

    localparam sev_t SCORE_MAX = 7'd100;
    localparam cnt_t CAP_RESET = 16'hFFFF;
    localparam cnt_t FLAG_MAX  = 16'hFFFF;

    localparam len_t LEN_LONG_HI  = LENGTH_BITS'(230000);
    localparam len_t LEN_LONG_MID = LENGTH_BITS'(210000);
    localparam len_t LEN_LONG_LO  = LENGTH_BITS'(200000);
    localparam len_t LEN_SHORT_HI = LENGTH_BITS'(160000);
    localparam len_t LEN_SHORT_MD = LENGTH_BITS'(170000);
    localparam len_t LEN_SHORT_LO = LENGTH_BITS'(180000);
    localparam len_t SPAN_STABLE  = LENGTH_BITS'(1000);
    localparam len_t SPAN_HUGE    = LENGTH_BITS'(8000);
    localparam len_t SPAN_WIDE    = LENGTH_BITS'(4000);

    function automatic sev_t grade_weak(logic [REV_W-1:0] revs, count_t bits, count_t run);
        sev_t s;
        s = '0;
        if (revs >= 8'd2 && bits != '0) begin
            if (run >= 18'd256) begin
                s = 7'd40;
            end else if (run >= 18'd128) begin
                s = 7'd25;
            end else if (run >= 18'd64) begin
                s = 7'd15;
            end
            if (bits >= 18'd1024) begin
                s = s + 7'd40;
            end else if (bits >= 18'd512) begin
                s = s + 7'd25;
            end else if (bits >= 18'd256) begin
                s = s + 7'd15;
            end
        end
        return s;
    endfunction

    function automatic sev_t grade_illegal(count_t n);
        sev_t s;
        if (n == '0) begin
            s = 7'd0;
        end else if (n >= 18'd200) begin
            s = 7'd90;
        end else if (n >= 18'd50) begin
            s = 7'd70;
        end else if (n >= 18'd10) begin
            s = 7'd50;
        end else begin
            s = 7'd25;
        end
        return s;
    endfunction

    function automatic sev_t grade_sync(count_t n);
        sev_t s;
        if (n == '0) begin
            s = 7'd0;
        end else if (n >= 18'd1200) begin
            s = 7'd90;
        end else if (n >= 18'd900) begin
            s = 7'd70;
        end else if (n >= 18'd700) begin
            s = 7'd50;
        end else if (n >= 18'd500) begin
            s = 7'd30;
        end else begin
            s = 7'd10;
        end
        return s;
    endfunction

    function automatic sev_t grade_length(len_t lo, len_t hi, logic [REV_W-1:0] revs,
                                          logic longer);
        logic huge;
        len_t span;
        sev_t s;
        huge = lo > hi;
        span = hi - lo;
        s    = '0;
        if (lo != '0 && hi != '0) begin
            if (!huge && span < SPAN_STABLE && revs >= 8'd2) begin
                if (longer) begin
                    if (hi >= LEN_LONG_HI) begin
                        s = 7'd85;
                    end else if (hi >= LEN_LONG_MID) begin
                        s = 7'd60;
                    end else if (hi >= LEN_LONG_LO) begin
                        s = 7'd40;
                    end
                end else begin
                    if (lo <= LEN_SHORT_HI) begin
                        s = 7'd85;
                    end else if (lo <= LEN_SHORT_MD) begin
                        s = 7'd60;
                    end else if (lo <= LEN_SHORT_LO) begin
                        s = 7'd40;
                    end
                end
            end else if (huge || span >= SPAN_HUGE) begin
                s = 7'd50;
            end else if (span >= SPAN_WIDE) begin
                s = 7'd30;
            end
        end
        return s;
    endfunction

    // Score added per hit: trait base plus severity over the trait divisor.
    function automatic incr_t score_incr(trait_t t, sev_t s);
        incr_t r;
        r = '0;
        unique case (t)
            TRAIT_WEAK: begin
                unique case (s)
                    7'd15:   r = 5'd11;
                    7'd25:   r = 5'd12;
                    7'd30:   r = 5'd13;
                    7'd40:   r = 5'd14;
                    7'd50:   r = 5'd15;
                    7'd55:   r = 5'd15;
                    7'd65:   r = 5'd16;
                    7'd80:   r = 5'd18;
                    default: r = 5'd0;
                endcase
            end
            TRAIT_LONG, TRAIT_SHORT: begin
                unique case (s)
                    7'd30:   r = 5'd10;
                    7'd40:   r = 5'd11;
                    7'd50:   r = 5'd12;
                    7'd60:   r = 5'd13;
                    7'd85:   r = 5'd15;
                    default: r = 5'd0;
                endcase
            end
            TRAIT_HALF: begin
                unique case (s)
                    7'd30:   r = 5'd12;
                    7'd70:   r = 5'd15;
                    default: r = 5'd0;
                endcase
            end
            TRAIT_ILLEGAL: begin
                unique case (s)
                    7'd25:   r = 5'd9;
                    7'd50:   r = 5'd11;
                    7'd70:   r = 5'd13;
                    7'd90:   r = 5'd14;
                    default: r = 5'd0;
                endcase
            end
            TRAIT_SYNC: begin
                unique case (s)
                    7'd10:   r = 5'd6;
                    7'd30:   r = 5'd7;
                    7'd50:   r = 5'd9;
                    7'd70:   r = 5'd10;
                    7'd90:   r = 5'd11;
                    default: r = 5'd0;
                endcase
            end
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/track_protection_trait_scorer.sv
// Top level: grades track capture metrics and streams trait hits and disk reports.
//
//  Channel   Ports            Direction  Transaction
//  s_        tdata/tlast      in         one track's metrics, tlast = last track
//  m_        tdata/tuser/tlast out       one hit or report, tuser = kind
//  apb       psel..prdata     in/out     hit_capacity register at byte 0
//
//  The work stage walks the pending traits of a track, lowest first, one trait a cycle
//  unless m_tready stalls it, then emits the report when the track was the last one.
//  Tracks with no hit and no report pass the input register and skip the work stage.
//  Reset is synchronous on aresetn low and needs no clearing pass.
//  A stall on m_tready holds the work stage; the input register still takes one track.
`default_nettype none

module track_protection_trait_scorer (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // revolutions, weak_total, weak_max_run, illegal_code_count, longest_sync_bits,
    // length_min, length_max, half_position, half_has_data, track_number, zero fill
    input  wire logic [tpts_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic                               s_tlast,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // hit_type, hit_track, severity, confidence, flagged_tracks, hits_emitted, zero fill
    output logic [tpts_pkg::M_TDATA_W-1:0]          m_tdata,
    // result_kind
    output logic                                    m_tuser,
    output logic                                    m_tlast,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [tpts_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [tpts_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tpts_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                    pready
);
    import tpts_pkg::*;

    logic                      a_valid_reg, a_valid_next;
    item_t                     a_item_reg, a_item_next;
    logic                      a_last_reg, a_last_next;

    sev_t                      a_sev [NUM_TRAITS];
    incr_t                     a_incr [NUM_TRAITS];
    logic [NUM_TRAITS-1:0]     a_hits;
    logic                      a_any;

    logic                      b_valid_reg, b_valid_next;
    sev_t                      b_sev_reg [NUM_TRAITS];
    sev_t                      b_sev_next [NUM_TRAITS];
    incr_t                     b_incr_reg [NUM_TRAITS];
    incr_t                     b_incr_next [NUM_TRAITS];
    logic [NUM_TRAITS-1:0]     b_pend_reg, b_pend_next;
    logic                      b_rep_reg, b_rep_next;
    logic [TRACK_W-1:0]        b_track_reg, b_track_next;

    sev_t                      score_reg, score_next;
    cnt_t                      flagged_reg, flagged_next;
    cnt_t                      emitted_reg, emitted_next;
    cnt_t                      cap_reg, cap_next;

    logic                      m_valid_reg, m_valid_next;
    logic                      m_kind_reg, m_kind_next;
    logic [TYPE_W-1:0]         m_type_reg, m_type_next;
    logic [TRACK_W-1:0]        m_track_reg, m_track_next;
    sev_t                      m_sev_reg, m_sev_next;
    sev_t                      m_conf_reg, m_conf_next;
    cnt_t                      m_flag_reg, m_flag_next;
    cnt_t                      m_emit_reg, m_emit_next;
    logic                      m_last_reg, m_last_next;

    logic                      s_accept;
    logic                      out_free;
    logic                      step;
    logic                      hit_step;
    logic                      rep_step;
    logic                      b_done;
    logic                      b_load;
    logic [TYPE_W-1:0]         pick;
    logic [NUM_TRAITS-1:0]     pend_rest;
    logic                      can_emit;
    logic [CNT_W:0]            emit_plus;
    logic                      more_room;
    logic [SEV_W:0]            score_sum;
    sev_t                      score_sat;
    cnt_t                      flag_base;
    logic                      cfg_we;

    // Grade the registered track
    always_comb begin
        a_sev[TRAIT_WEAK]    = grade_weak(a_item_reg.revolutions, a_item_reg.weak_total,
                                          a_item_reg.weak_max_run);
        a_sev[TRAIT_LONG]    = grade_length(a_item_reg.length_min, a_item_reg.length_max,
                                            a_item_reg.revolutions, 1'b1);
        a_sev[TRAIT_SHORT]   = grade_length(a_item_reg.length_min, a_item_reg.length_max,
                                            a_item_reg.revolutions, 1'b0);
        a_sev[TRAIT_HALF]    = a_item_reg.half_position ?
                               (a_item_reg.half_has_data ? 7'd70 : 7'd30) : 7'd0;
        a_sev[TRAIT_ILLEGAL] = grade_illegal(a_item_reg.illegal_code_count);
        a_sev[TRAIT_SYNC]    = grade_sync(a_item_reg.longest_sync_bits);
        for (int i = 0; i < NUM_TRAITS; i++) begin
            a_incr[i] = score_incr(trait_t'(TYPE_W'(i)), a_sev[i]);
            a_hits[i] = a_sev[i] != '0;
        end
        a_any = |a_hits;
    end

    // Pick the lowest pending trait
    always_comb begin
        pick = '0;
        for (int i = NUM_TRAITS - 1; i >= 0; i--) begin
            if (b_pend_reg[i]) begin
                pick = TYPE_W'(i);
            end
        end
    end

    assign pend_rest = b_pend_reg & (b_pend_reg - 1'b1);
    assign out_free  = !m_valid_reg || m_tready;
    assign step      = b_valid_reg && out_free;
    assign hit_step  = step && (b_pend_reg != '0);
    assign rep_step  = step && (b_pend_reg == '0) && b_rep_reg;
    assign b_done    = rep_step || (hit_step && (pend_rest == '0) && !b_rep_reg);
    assign b_load    = a_valid_reg && (!b_valid_reg || b_done);
    assign s_tready  = !a_valid_reg || b_load;
    assign s_accept  = s_tvalid && s_tready;

    assign can_emit  = emitted_reg < cap_reg;
    assign emit_plus = {1'b0, emitted_reg} + 17'd1;
    assign more_room = emit_plus < {1'b0, cap_reg};
    assign score_sum = {1'b0, score_reg} + {3'b000, b_incr_reg[pick]};
    assign score_sat = (score_sum > {1'b0, SCORE_MAX}) ? SCORE_MAX : score_sum[SEV_W-1:0];
    assign flag_base = rep_step ? '0 : flagged_reg;

    assign cfg_we    = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_HIT_CAPACITY) ?
                       {{(APB_DATA_W - CNT_W){1'b0}}, cap_reg} : '0;

    always_comb begin
        a_valid_next = a_valid_reg;
        a_item_next  = a_item_reg;
        a_last_next  = a_last_reg;
        if (s_accept) begin
            a_valid_next = 1'b1;
            a_item_next  = s_tdata[$bits(item_t)-1:0];
            a_last_next  = s_tlast;
        end else if (b_load) begin
            a_valid_next = 1'b0;
        end
    end

    always_comb begin
        b_valid_next = b_valid_reg;
        b_sev_next   = b_sev_reg;
        b_incr_next  = b_incr_reg;
        b_pend_next  = b_pend_reg;
        b_rep_next   = b_rep_reg;
        b_track_next = b_track_reg;
        if (b_load) begin
            b_valid_next = a_any || a_last_reg;
            b_sev_next   = a_sev;
            b_incr_next  = a_incr;
            b_pend_next  = a_hits;
            b_rep_next   = a_last_reg;
            b_track_next = a_item_reg.track_number;
        end else if (b_done) begin
            b_valid_next = 1'b0;
            b_pend_next  = '0;
            b_rep_next   = 1'b0;
        end else if (hit_step) begin
            b_pend_next  = pend_rest;
        end
    end

    always_comb begin
        score_next   = score_reg;
        emitted_next = emitted_reg;
        cap_next     = cap_reg;
        if (rep_step) begin
            score_next   = '0;
            emitted_next = '0;
        end else if (hit_step) begin
            score_next = score_sat;
            if (can_emit) begin
                emitted_next = emit_plus[CNT_W-1:0];
            end
        end
        flagged_next = (b_load && a_any && flag_base != FLAG_MAX) ?
                       flag_base + 16'd1 : flag_base;
        if (cfg_we && paddr[2] == REG_HIT_CAPACITY) begin
            cap_next = pwdata[CNT_W-1:0];
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_kind_next  = m_kind_reg;
        m_type_next  = m_type_reg;
        m_track_next = m_track_reg;
        m_sev_next   = m_sev_reg;
        m_conf_next  = m_conf_reg;
        m_flag_next  = m_flag_reg;
        m_emit_next  = m_emit_reg;
        m_last_next  = m_last_reg;
        if (out_free) begin
            m_valid_next = (hit_step && can_emit) || rep_step;
            if (rep_step) begin
                m_kind_next  = KIND_REPORT;
                m_type_next  = '0;
                m_track_next = '0;
                m_sev_next   = '0;
                m_conf_next  = score_reg;
                m_flag_next  = flagged_reg;
                m_emit_next  = emitted_reg;
                m_last_next  = 1'b1;
            end else begin
                m_kind_next  = KIND_HIT;
                m_type_next  = pick;
                m_track_next = b_track_reg;
                m_sev_next   = b_sev_reg[pick];
                m_conf_next  = '0;
                m_flag_next  = '0;
                m_emit_next  = '0;
                m_last_next  = !b_rep_reg && ((pend_rest == '0) || !more_room);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            b_pend_reg  <= '0;
            b_rep_reg   <= 1'b0;
            score_reg   <= '0;
            flagged_reg <= '0;
            emitted_reg <= '0;
            cap_reg     <= CAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            b_pend_reg  <= b_pend_next;
            b_rep_reg   <= b_rep_next;
            score_reg   <= score_next;
            flagged_reg <= flagged_next;
            emitted_reg <= emitted_next;
            cap_reg     <= cap_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_item_reg  <= a_item_next;
        a_last_reg  <= a_last_next;
        b_sev_reg   <= b_sev_next;
        b_incr_reg  <= b_incr_next;
        b_track_reg <= b_track_next;
        m_kind_reg  <= m_kind_next;
        m_type_reg  <= m_type_next;
        m_track_reg <= m_track_next;
        m_sev_reg   <= m_sev_next;
        m_conf_reg  <= m_conf_next;
        m_flag_reg  <= m_flag_next;
        m_emit_reg  <= m_emit_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(M_TDATA_W - 57){1'b0}}, m_emit_reg, m_flag_reg, m_conf_reg,
                       m_sev_reg, m_track_reg, m_type_reg};

`ifndef SYNTHESIS
    a_score_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        score_reg <= SCORE_MAX)
        else $error("score above saturation limit");

    a_report_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_kind_reg == KIND_REPORT |-> m_last_reg)
        else $error("report not marked as final result");

    a_report_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        rep_step |=> score_reg == '0 && emitted_reg == '0)
        else $error("state not cleared after report");

    a_work_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg |-> (b_pend_reg != '0) || b_rep_reg)
        else $error("work stage valid with nothing to do");

    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> a_valid_reg && b_valid_reg)
        else $error("input stalled with free stage");
`endif

endmodule

`default_nettype wire

### verif/tb_track_protection_trait_scorer.sv
// Self-checking testbench for the track protection trait scorer: directed table, then random disks.
`default_nettype none

module tb_track_protection_trait_scorer;
    import tpts_pkg::*;

    typedef struct packed {
        logic       kind;
        logic [2:0] htype;
        logic [7:0] track;
        sev_t       sev;
        sev_t       conf;
        cnt_t       flagged;
        cnt_t       emitted;
        logic       last;
    } track_result_t;

    typedef struct packed {
        logic          set_cap;
        cnt_t          cap;
        item_t         it;
        logic          last;
        logic          typed;
        track_result_t want;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    track_result_t pending_results[$];
    track_result_t track_out[$];
    stim_row_t     plan[$];

    int   disk_score;
    int   flagged_total;
    int   emitted_hits;
    int   hit_cap;
    int   faults;
    int   tracks_sent;
    int   results_checked;
    int   reports_seen;
    int   cap_writes;
    logic no_idle;

    track_protection_trait_scorer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(12 * 400000);
        $display("[track_protection_trait_scorer] ERROR");
        $finish;
    end

    function automatic int weak_severity(int revs, int bits, int run);
        int s;
        s = 0;
        if (revs < 2 || bits == 0) return 0;
        if (run >= 256) s += 40;
        else if (run >= 128) s += 25;
        else if (run >= 64) s += 15;
        if (bits >= 1024) s += 40;
        else if (bits >= 512) s += 25;
        else if (bits >= 256) s += 15;
        return s;
    endfunction

    function automatic int length_severity(int lo, int hi, int revs, bit longer);
        bit inverted;
        int span;
        if (lo == 0 || hi == 0) return 0;
        inverted = lo > hi;
        span = inverted ? 0 : hi - lo;
        if (!inverted && span < 1000 && revs >= 2) begin
            if (longer) begin
                if (hi >= 230000) return 85;
                if (hi >= 210000) return 60;
                if (hi >= 200000) return 40;
            end else begin
                if (lo <= 160000) return 85;
                if (lo <= 170000) return 60;
                if (lo <= 180000) return 40;
            end
            return 0;
        end
        if (inverted || span >= 8000) return 50;
        if (span >= 4000) return 30;
        return 0;
    endfunction

    function automatic int illegal_severity(int n);
        if (n == 0) return 0;
        if (n >= 200) return 90;
        if (n >= 50) return 70;
        if (n >= 10) return 50;
        return 25;
    endfunction

    function automatic int sync_severity(int n);
        if (n == 0) return 0;
        if (n >= 1200) return 90;
        if (n >= 900) return 70;
        if (n >= 700) return 50;
        if (n >= 500) return 30;
        return 10;
    endfunction

    function automatic int score_step(int k, int sev);
        case (trait_t'(k))
            TRAIT_WEAK:               return 10 + sev / 10;
            TRAIT_LONG, TRAIT_SHORT:  return 8 + sev / 12;
            TRAIT_HALF:               return 10 + sev / 14;
            TRAIT_ILLEGAL:            return 8 + sev / 14;
            default:                  return 6 + sev / 16;
        endcase
    endfunction

    function automatic void grade_track(item_t it, logic last);
        int            sev[NUM_TRAITS];
        track_result_t r;
        logic          flagged;
        flagged = 1'b0;
        track_out.delete();
        sev[TRAIT_WEAK]    = weak_severity(int'(it.revolutions), int'(it.weak_total),
                                           int'(it.weak_max_run));
        sev[TRAIT_LONG]    = length_severity(int'(it.length_min), int'(it.length_max),
                                             int'(it.revolutions), 1'b1);
        sev[TRAIT_SHORT]   = length_severity(int'(it.length_min), int'(it.length_max),
                                             int'(it.revolutions), 1'b0);
        sev[TRAIT_HALF]    = it.half_position ? (it.half_has_data ? 70 : 30) : 0;
        sev[TRAIT_ILLEGAL] = illegal_severity(int'(it.illegal_code_count));
        sev[TRAIT_SYNC]    = sync_severity(int'(it.longest_sync_bits));
        for (int k = 0; k < NUM_TRAITS; k++) begin
            if (sev[k] != 0) begin
                flagged = 1'b1;
                disk_score += score_step(k, sev[k]);
                if (disk_score > 100) disk_score = 100;
                if (emitted_hits < hit_cap) begin
                    r = '0;
                    r.kind  = KIND_HIT;
                    r.htype = trait_t'(k);
                    r.track = it.track_number;
                    r.sev   = sev_t'(sev[k]);
                    track_out.push_back(r);
                    emitted_hits = (emitted_hits + 1) & 16'hFFFF;
                end
            end
        end
        if (flagged && flagged_total < 65535) flagged_total++;
        if (last) begin
            r = '0;
            r.kind    = KIND_REPORT;
            r.conf    = sev_t'(disk_score);
            r.flagged = cnt_t'(flagged_total);
            r.emitted = cnt_t'(emitted_hits);
            track_out.push_back(r);
            disk_score    = 0;
            flagged_total = 0;
            emitted_hits  = 0;
        end
        if (track_out.size() > 0) begin
            r = track_out.pop_back();
            r.last = 1'b1;
            track_out.push_back(r);
        end
    endfunction

    function automatic item_t mk_track(int rev, int wbits, int wrun, int ill, int sync,
                                       int lmin, int lmax, bit half, bit hdata, int trk);
        item_t it;
        it.revolutions        = REV_W'(rev);
        it.weak_total         = count_t'(wbits);
        it.weak_max_run       = count_t'(wrun);
        it.illegal_code_count = count_t'(ill);
        it.longest_sync_bits  = count_t'(sync);
        it.length_min         = len_t'(lmin);
        it.length_max         = len_t'(lmax);
        it.half_position      = half;
        it.half_has_data      = hdata;
        it.track_number       = TRACK_W'(trk);
        return it;
    endfunction

    function automatic void add_row(logic set_cap, int cap, item_t it, logic last,
                                    logic typed, track_result_t want);
        stim_row_t row;
        row.set_cap = set_cap;
        row.cap     = cnt_t'(cap);
        row.it      = it;
        row.last    = last;
        row.typed   = typed;
        row.want    = want;
        plan.push_back(row);
    endfunction

    function automatic count_t rand_count();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return '0;
        if (r < 8) return count_t'($urandom_range(0, 1500));
        return count_t'($urandom);
    endfunction

    function automatic item_t rand_track();
        item_t it;
        int    r;
        int    base;
        int    spread;
        len_t  swap;
        it.revolutions        = REV_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                                   : $urandom_range(0, 255));
        it.weak_total         = rand_count();
        it.weak_max_run       = rand_count();
        it.illegal_code_count = rand_count();
        it.longest_sync_bits  = rand_count();
        r = $urandom_range(0, 19);
        if (r < 3) begin
            it.length_min = (r == 0) ? len_t'(0) : len_t'($urandom);
            it.length_max = (r == 1) ? len_t'(0) : len_t'($urandom);
        end else if (r < 6) begin
            it.length_min = len_t'($urandom);
            it.length_max = len_t'($urandom);
        end else begin
            base   = $urandom_range(150000, 240000);
            spread = (r < 14) ? $urandom_range(0, 1100) : $urandom_range(0, 9500);
            it.length_min = len_t'(base);
            it.length_max = len_t'(base + spread);
            if (r == 19) begin
                swap          = it.length_min;
                it.length_min = it.length_max;
                it.length_max = swap;
            end
        end
        it.half_position = 1'($urandom_range(0, 1));
        it.half_has_data = 1'($urandom_range(0, 1));
        it.track_number  = TRACK_W'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            faults++;
            $display("%0t mismatch %s: expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    task automatic send_track(input item_t it, input logic last, input logic typed,
                              input track_result_t want);
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(it);
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracks_sent++;
        grade_track(it, last);
        if (typed) begin
            pending_results.push_back(want);
        end else begin
            foreach (track_out[i]) pending_results.push_back(track_out[i]);
        end
    endtask

    task automatic idle_maybe();
        if (!no_idle && $urandom_range(0, 99) < 10) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    // hold the sender until every expected transaction is out, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_capacity(input int value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(REG_HIT_CAPACITY));
        pwdata  <= APB_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        hit_cap = value & 16'hFFFF;
        cap_writes++;
    endtask

    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 10);
    end

    always @(posedge aclk) begin : check_result
        track_result_t got;
        track_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind    = m_tuser;
            got.htype   = m_tdata[2:0];
            got.track   = m_tdata[10:3];
            got.sev     = m_tdata[17:11];
            got.conf    = m_tdata[24:18];
            got.flagged = m_tdata[40:25];
            got.emitted = m_tdata[56:41];
            got.last    = m_tlast;
            if (pending_results.size() == 0) begin
                faults++;
                $display("%0t unexpected transaction: expected none, got kind %0d data %h",
                         $time, got.kind, m_tdata);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (got.kind == KIND_REPORT) reports_seen++;
                check_field("result_kind", 32'(want.kind), 32'(got.kind));
                check_field("hit_type", 32'(want.htype), 32'(got.htype));
                check_field("hit_track", 32'(want.track), 32'(got.track));
                check_field("severity", 32'(want.sev), 32'(got.sev));
                check_field("confidence", 32'(want.conf), 32'(got.conf));
                check_field("flagged_tracks", 32'(want.flagged), 32'(got.flagged));
                check_field("hits_emitted", 32'(want.emitted), 32'(got.emitted));
                check_field("last_result", 32'(want.last), 32'(got.last));
            end
        end
    end

    initial begin
        item_t         every_trait;
        item_t         blank;
        track_result_t want;
        int            caps[6];

        disk_score    = 0;
        flagged_total = 0;
        emitted_hits  = 0;
        hit_cap       = 65535;
        faults        = 0;
        tracks_sent   = 0;
        results_checked = 0;
        reports_seen  = 0;
        cap_writes    = 0;
        no_idle       = 1'b0;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        m_tready <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;

        blank       = mk_track(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        every_trait = mk_track(2, 1024, 256, 200, 1200, 262143, 1, 1, 1, 170);

        want = '0;
        want.kind = KIND_REPORT;
        want.last = 1'b1;
        add_row(0, 0, blank, 1, 1, want);
        want = '0;
        want.kind  = KIND_HIT;
        want.htype = TRAIT_ILLEGAL;
        want.track = 8'd255;
        want.sev   = 7'd90;
        want.last  = 1'b1;
        add_row(0, 0, mk_track(0, 0, 0, 262143, 0, 0, 0, 0, 0, 255), 0, 1, want);
        want = '0;
        want.kind    = KIND_REPORT;
        want.conf    = 7'd14;
        want.flagged = 16'd1;
        want.emitted = 16'd1;
        want.last    = 1'b1;
        add_row(0, 0, blank, 1, 1, want);

        add_row(0, 0, mk_track(2, 1024, 256, 0, 0, 0, 0, 0, 0, 1), 0, 0, '0);
        add_row(0, 0, mk_track(1, 262143, 262143, 0, 0, 0, 0, 0, 0, 2), 0, 0, '0);
        add_row(0, 0, mk_track(255, 256, 64, 0, 0, 0, 0, 0, 0, 3), 0, 0, '0);
        add_row(0, 0, mk_track(2, 1, 0, 0, 0, 0, 0, 0, 0, 4), 0, 0, '0);
        add_row(0, 0, mk_track(2, 0, 0, 0, 0, 229500, 230000, 0, 0, 5), 0, 0, '0);
        add_row(0, 0, mk_track(3, 0, 0, 0, 0, 160000, 160500, 0, 0, 6), 0, 0, '0);
        add_row(0, 0, mk_track(2, 0, 0, 0, 0, 180000, 180999, 0, 0, 7), 0, 0, '0);
        add_row(0, 0, mk_track(2, 0, 0, 0, 0, 262143, 1, 0, 0, 8), 0, 0, '0);
        add_row(0, 0, mk_track(2, 0, 0, 0, 0, 0, 262143, 0, 0, 9), 0, 0, '0);
        add_row(0, 0, mk_track(2, 0, 0, 0, 0, 262143, 0, 0, 0, 10), 0, 0, '0);
        add_row(0, 0, mk_track(2, 0, 0, 0, 0, 100000, 104000, 0, 0, 11), 0, 0, '0);
        add_row(0, 0, mk_track(2, 0, 0, 0, 0, 100000, 108000, 0, 0, 12), 0, 0, '0);
        add_row(0, 0, mk_track(1, 0, 0, 0, 0, 200000, 200000, 0, 0, 13), 0, 0, '0);
        add_row(0, 0, mk_track(2, 0, 0, 0, 0, 0, 0, 1, 0, 14), 0, 0, '0);
        add_row(0, 0, mk_track(2, 0, 0, 0, 0, 0, 0, 1, 1, 15), 0, 0, '0);
        add_row(0, 0, mk_track(2, 0, 0, 0, 0, 0, 0, 0, 1, 16), 0, 0, '0);
        add_row(0, 0, mk_track(0, 0, 0, 0, 1200, 0, 0, 0, 0, 17), 0, 0, '0);
        add_row(0, 0, mk_track(0, 0, 0, 0, 499, 0, 0, 0, 0, 18), 1, 0, '0);
        add_row(0, 0, every_trait, 1, 0, '0);
        add_row(1, 0, every_trait, 1, 0, '0);
        add_row(1, 2, every_trait, 0, 0, '0);
        add_row(0, 0, mk_track(0, 0, 0, 5, 262143, 0, 0, 0, 0, 19), 1, 0, '0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].set_cap) write_capacity(int'(plan[i].cap));
            send_track(plan[i].it, plan[i].last, plan[i].typed, plan[i].want);
            idle_maybe();
        end

        caps[0] = 65535;
        caps[1] = 1;
        caps[2] = 0;
        caps[3] = 3;
        caps[4] = $urandom_range(0, 65535);
        caps[5] = 65535;
        for (int p = 0; p < 6; p++) begin
            write_capacity(caps[p]);
            no_idle = (p == 2);
            for (int n = 0; n < 24; n++) begin
                if (p == 3 && n == 14) drain();
                send_track(rand_track(), $urandom_range(0, 7) == 0, 1'b0, '0);
                idle_maybe();
            end
        end
        no_idle = 1'b0;

        drain();
        $display("sent %0d tracks over %0d capacity settings", tracks_sent, cap_writes);
        $display("checked %0d transactions, %0d of them disk reports",
                 results_checked, reports_seen);
        if (faults == 0) begin
            $display("[track_protection_trait_scorer] OK");
        end else begin
            $display("[track_protection_trait_scorer] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
hdl/tpts_pkg.sv
hdl/track_protection_trait_scorer.sv
verif/tb_track_protection_trait_scorer.sv
